FILE: rtl/core/btp_pkg.sv
// BTHome v2 object parser: shared types, codes and the object length table.
// Used by btp_step and bthome_v2_object_parser; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package btp_pkg;

    // Parse phase codes
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_ID     = 3'd1;
    localparam logic [2:0] PH_LENGTH = 3'd2;
    localparam logic [2:0] PH_VALUE  = 3'd3;
    localparam logic [2:0] PH_IGNORE = 3'd4;

    // Byte role codes
    localparam logic [2:0] ROLE_HEADER_OK   = 3'd0;
    localparam logic [2:0] ROLE_REJ_ENCRYPT = 3'd1;
    localparam logic [2:0] ROLE_REJ_VERSION = 3'd2;
    localparam logic [2:0] ROLE_OBJECT_ID   = 3'd3;
    localparam logic [2:0] ROLE_VALUE       = 3'd4;
    localparam logic [2:0] ROLE_PACKET_ID   = 3'd5;
    localparam logic [2:0] ROLE_IGNORED     = 3'd6;
    localparam logic [2:0] ROLE_UNKNOWN_ID  = 3'd7;

    // End status codes
    localparam logic [1:0] STATUS_COMPLETE  = 2'd0;
    localparam logic [1:0] STATUS_REJECTED  = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
    localparam logic [1:0] STATUS_UNKNOWN   = 2'd3;

    // Length codes: 0 unknown, 1..4 fixed bytes, 5 length byte follows
    localparam logic [2:0] LEN_UNKNOWN  = 3'd0;
    localparam logic [2:0] LEN_VARIABLE = 3'd5;

    localparam logic [7:0] HDR_ENCRYPT_MASK = 8'h01;
    localparam logic [2:0] BTHOME_VERSION   = 3'd2;
    localparam logic [7:0] PACKET_ID_OBJ    = 8'h00;
    localparam logic [7:0] COUNT_MAX        = 8'hFF;

    localparam int TABLE_DEPTH = 98;
    localparam logic [7:0] TABLE_LIMIT = 8'(TABLE_DEPTH);

    localparam logic [2:0] LEN_TABLE [0:TABLE_DEPTH-1] = '{
        3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd2, 3'd2,
        3'd2, 3'd1, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd1,
        3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd1, 3'd0, 3'd2, 3'd2, 3'd4, 3'd2,
        3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd2, 3'd1, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd4, 3'd2, 3'd2, 3'd5, 3'd5, 3'd4, 3'd2, 3'd1,
        3'd1, 3'd1, 3'd2, 3'd4, 3'd4, 3'd2, 3'd2, 3'd2,
        3'd1, 3'd2
    };

    // Parser state carried from one item to the next
    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] current_object;
        logic [7:0] bytes_remaining;
        logic [7:0] packet_number;
        logic [7:0] measurement_count;
        logic [1:0] stop_status;
    } btp_state_t;

    // One result item
    typedef struct packed {
        logic [2:0] byte_role;
        logic [7:0] object_code;
        logic [7:0] byte_value;
        logic       measurement_done;
        logic       payload_end;
        logic [1:0] end_status;
        logic [7:0] packet_number;
        logic [7:0] measurement_total;
    } btp_result_t;

    localparam btp_state_t STATE_RESET = '{
        phase:             PH_HEADER,
        current_object:    8'd0,
        bytes_remaining:   8'd0,
        packet_number:     8'd0,
        measurement_count: 8'd0,
        stop_status:       STATUS_COMPLETE
    };

    // Value length of an object id
    function automatic logic [2:0] object_length(input logic [7:0] id);
        logic [2:0] len;
        len = LEN_UNKNOWN;
        if (id < TABLE_LIMIT) begin
            len = LEN_TABLE[id[6:0]];
        end else begin
            case (id)
                8'hF0:   len = 3'd2;
                8'hF1:   len = 3'd4;
                8'hF2:   len = 3'd3;
                default: len = LEN_UNKNOWN;
            endcase
        end
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/btp_in_if.sv
// Input channel of the BTHome parser: one payload byte per item.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface btp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/btp_out_if.sv
// Output channel of the BTHome parser: one tagged result per item.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface btp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] byte_role;
    logic [7:0] object_code;
    logic [7:0] byte_value;
    logic       measurement_done;
    logic       payload_end;
    logic [1:0] end_status;
    logic [7:0] packet_number;
    logic [7:0] measurement_total;

    modport source (
        output valid, output byte_role, output object_code, output byte_value,
        output measurement_done, output payload_end, output end_status,
        output packet_number, output measurement_total, input ready
    );
    modport sink (
        input valid, input byte_role, input object_code, input byte_value,
        input measurement_done, input payload_end, input end_status,
        input packet_number, input measurement_total, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/btp_step.sv
// One parse step: next parser state and the result for one payload byte.
// Depends on btp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btp_step (
    input  wire btp_pkg::btp_state_t  state,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 last_byte,
    output btp_pkg::btp_state_t       state_next,
    output btp_pkg::btp_result_t      result
);

    btp_pkg::btp_state_t upd;
    logic [2:0]          role;
    logic [7:0]          code;
    logic                done;
    logic [2:0]          len;
    logic [1:0]          status;
    logic [7:0]          remaining_dec;

    assign len = btp_pkg::object_length(data_byte);
    assign remaining_dec = (state.bytes_remaining != 8'd0)
                         ? state.bytes_remaining - 8'd1 : 8'd0;

    // Phase machine
    always_comb
    begin
        upd  = state;
        role = btp_pkg::ROLE_IGNORED;
        code = 8'd0;
        done = 1'b0;
        unique case (state.phase)
            btp_pkg::PH_HEADER:
            begin
                if ((data_byte & btp_pkg::HDR_ENCRYPT_MASK) != 8'd0) begin
                    role = btp_pkg::ROLE_REJ_ENCRYPT;
                    upd.stop_status = btp_pkg::STATUS_REJECTED;
                    upd.phase = btp_pkg::PH_IGNORE;
                end else if (data_byte[7:5] != btp_pkg::BTHOME_VERSION) begin
                    role = btp_pkg::ROLE_REJ_VERSION;
                    upd.stop_status = btp_pkg::STATUS_REJECTED;
                    upd.phase = btp_pkg::PH_IGNORE;
                end else begin
                    role = btp_pkg::ROLE_HEADER_OK;
                    upd.phase = btp_pkg::PH_ID;
                end
            end
            btp_pkg::PH_ID:
            begin
                code = data_byte;
                if (last_byte) begin
                    // id with nothing after it
                    role = btp_pkg::ROLE_OBJECT_ID;
                    upd.stop_status = btp_pkg::STATUS_TRUNCATED;
                    upd.phase = btp_pkg::PH_IGNORE;
                end else if (len == btp_pkg::LEN_UNKNOWN) begin
                    role = btp_pkg::ROLE_UNKNOWN_ID;
                    upd.stop_status = btp_pkg::STATUS_UNKNOWN;
                    upd.phase = btp_pkg::PH_IGNORE;
                end else if (len == btp_pkg::LEN_VARIABLE) begin
                    role = btp_pkg::ROLE_OBJECT_ID;
                    upd.current_object = data_byte;
                    upd.phase = btp_pkg::PH_LENGTH;
                end else begin
                    role = btp_pkg::ROLE_OBJECT_ID;
                    upd.current_object = data_byte;
                    upd.bytes_remaining = {5'd0, len};
                    upd.phase = btp_pkg::PH_VALUE;
                end
            end
            btp_pkg::PH_LENGTH:
            begin
                role = btp_pkg::ROLE_VALUE;
                code = state.current_object;
                if (data_byte == 8'd0) begin
                    done = 1'b1;
                    if (state.measurement_count != btp_pkg::COUNT_MAX) begin
                        upd.measurement_count = state.measurement_count + 8'd1;
                    end
                    upd.phase = btp_pkg::PH_ID;
                end else begin
                    upd.bytes_remaining = data_byte;
                    upd.phase = btp_pkg::PH_VALUE;
                end
            end
            btp_pkg::PH_VALUE:
            begin
                code = state.current_object;
                if (state.current_object == btp_pkg::PACKET_ID_OBJ) begin
                    role = btp_pkg::ROLE_PACKET_ID;
                    upd.packet_number = data_byte;
                end else begin
                    role = btp_pkg::ROLE_VALUE;
                end
                upd.bytes_remaining = remaining_dec;
                if (remaining_dec == 8'd0) begin
                    done = 1'b1;
                    if (state.current_object != btp_pkg::PACKET_ID_OBJ
                        && state.measurement_count != btp_pkg::COUNT_MAX) begin
                        upd.measurement_count = state.measurement_count + 8'd1;
                    end
                    upd.phase = btp_pkg::PH_ID;
                end
            end
            default:
            begin
                // ignore phase and unused codes
                role = btp_pkg::ROLE_IGNORED;
            end
        endcase
    end

    // End status on the last byte
    always_comb
    begin
        status = btp_pkg::STATUS_COMPLETE;
        if (last_byte) begin
            if (upd.phase == btp_pkg::PH_ID) begin
                status = btp_pkg::STATUS_COMPLETE;
            end else if (upd.phase == btp_pkg::PH_LENGTH
                         || upd.phase == btp_pkg::PH_VALUE) begin
                status = btp_pkg::STATUS_TRUNCATED;
            end else begin
                status = upd.stop_status;
            end
        end
    end

    assign result.byte_role         = role;
    assign result.object_code       = code;
    assign result.byte_value        = data_byte;
    assign result.measurement_done  = done;
    assign result.payload_end       = last_byte;
    assign result.end_status        = status;
    assign result.packet_number     = upd.packet_number;
    assign result.measurement_total = upd.measurement_count;

    // Back to reset values once the payload ends
    assign state_next = last_byte ? btp_pkg::STATE_RESET : upd;

endmodule

`default_nettype wire

FILE: rtl/core/bthome_v2_object_parser.sv
// BTHome v2 object parser top level: state register and result register.
// Depends on btp_pkg, btp_in_if, btp_out_if and btp_step.
//
// Usage:
//   payload: one service-data byte per item (data_byte, last_byte), the
//            first byte of each payload being the device-info header.
//   result:  one item per input byte, tagging its role, the object it
//            belongs to, measurement completion and running totals; the
//            result of the last byte carries payload_end and end_status.
//   Result valid rises in the cycle after input acceptance. One byte per
//   cycle is sustained while the receiver is ready: the state update and
//   length table lookup sit between the parser state and result registers.
//   A new byte is taken whenever the result register is empty or is being
//   drained in the same cycle; while the receiver stalls the result holds
//   and at most one byte is absorbed before payload.ready drops.
//   Reset clears the result valid flag and returns the parser to expecting a
//   header byte. After a last byte the parser resets itself the same way.
`timescale 1ns / 1ps
`default_nettype none

module bthome_v2_object_parser (
    input  wire logic  clk,
    input  wire logic  rst_n,
    btp_in_if.sink     payload,
    btp_out_if.source  result
);

    btp_pkg::btp_state_t  state_reg;
    btp_pkg::btp_state_t  state_next;
    btp_pkg::btp_result_t step_result;
    btp_pkg::btp_result_t result_reg;
    logic                 valid_reg;
    logic                 accept;

    assign payload.ready = !valid_reg || result.ready;
    assign accept        = payload.valid && payload.ready;

    btp_step u_step (
        .state      (state_reg),
        .data_byte  (payload.data_byte),
        .last_byte  (payload.last_byte),
        .state_next (state_next),
        .result     (step_result)
    );

    // Parser state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= btp_pkg::STATE_RESET;
            valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end else if (result.ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept) begin
            result_reg <= step_result;
        end
    end

    assign result.valid             = valid_reg;
    assign result.byte_role         = result_reg.byte_role;
    assign result.object_code       = result_reg.object_code;
    assign result.byte_value        = result_reg.byte_value;
    assign result.measurement_done  = result_reg.measurement_done;
    assign result.payload_end       = result_reg.payload_end;
    assign result.end_status        = result_reg.end_status;
    assign result.packet_number     = result_reg.packet_number;
    assign result.measurement_total = result_reg.measurement_total;

endmodule

`default_nettype wire

FILE: tb/sv/bthome_v2_object_parser_test.sv
// Self-checking testbench for the BTHome v2 object parser: payload bytes in, tagged results out.
// Depends on btp_pkg, btp_in_if, btp_out_if and bthome_v2_object_parser.
`timescale 1ns / 1ps

module bthome_v2_object_parser_test;

    // Object ids named by the stimulus
    localparam logic [7:0] OBJ_BATTERY = 8'h01;
    localparam logic [7:0] OBJ_TEXT    = 8'h53;
    localparam logic [7:0] OBJ_RAW     = 8'h54;
    localparam logic [7:0] EXT_ID_BASE = 8'hF0;
    localparam int         TABLE_IDS   = 98;

    // Value bytes per object id 0x00..0x61, then per extended id 0xF0..0xF2
    localparam logic [2:0] OBJ_BYTES [0:TABLE_IDS-1] = '{
        3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd2, 3'd2,
        3'd2, 3'd1, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd1,
        3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd1, 3'd0, 3'd2, 3'd2, 3'd4, 3'd2,
        3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd2, 3'd1, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd4, 3'd2, 3'd2, 3'd5, 3'd5, 3'd4, 3'd2, 3'd1,
        3'd1, 3'd1, 3'd2, 3'd4, 3'd4, 3'd2, 3'd2, 3'd2,
        3'd1, 3'd2
    };
    localparam logic [2:0] EXT_BYTES [0:2] = '{3'd2, 3'd4, 3'd3};

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int ITEM_TARGET      = 1100;
    localparam int MAX_REPORTS      = 10;

    // Parser predictor and store of expected tagged results
    class parser_scoreboard;
        btp_pkg::btp_result_t expected_q[$];
        logic [2:0]  phase;
        logic [7:0]  cur_obj;
        logic [7:0]  remaining;
        logic [7:0]  pkt_num;
        logic [7:0]  meas_cnt;
        logic [1:0]  stop_code;
        int unsigned errors;
        int unsigned checked;
        int unsigned ends [4];
        logic [7:0]  peak_total;

        function new();
            errors = 0;
            checked = 0;
            peak_total = 8'd0;
            foreach (ends[i]) ends[i] = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase     = btp_pkg::PH_HEADER;
            cur_obj   = 8'd0;
            remaining = 8'd0;
            pkt_num   = 8'd0;
            meas_cnt  = 8'd0;
            stop_code = btp_pkg::STATUS_COMPLETE;
        endfunction

        function logic [2:0] value_length(input logic [7:0] id);
            if (id < 8'(TABLE_IDS))
                return OBJ_BYTES[id[6:0]];
            if (id >= EXT_ID_BASE && id <= EXT_ID_BASE + 8'd2)
                return EXT_BYTES[2'(id - EXT_ID_BASE)];
            return btp_pkg::LEN_UNKNOWN;
        endfunction

        function void bump_count();
            if (meas_cnt != btp_pkg::COUNT_MAX) meas_cnt = meas_cnt + 8'd1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the parser by one accepted byte and queue its result
        function void note_byte(input logic [7:0] b, input logic l);
            btp_pkg::btp_result_t r;
            logic [2:0]  len;
            r = '0;
            r.byte_role   = btp_pkg::ROLE_IGNORED;
            r.byte_value  = b;
            r.payload_end = l;
            case (phase)
                btp_pkg::PH_HEADER: begin
                    if ((b & btp_pkg::HDR_ENCRYPT_MASK) != 8'd0) begin
                        r.byte_role = btp_pkg::ROLE_REJ_ENCRYPT;
                        stop_code = btp_pkg::STATUS_REJECTED;
                        phase = btp_pkg::PH_IGNORE;
                    end else if (b[7:5] != btp_pkg::BTHOME_VERSION) begin
                        r.byte_role = btp_pkg::ROLE_REJ_VERSION;
                        stop_code = btp_pkg::STATUS_REJECTED;
                        phase = btp_pkg::PH_IGNORE;
                    end else begin
                        r.byte_role = btp_pkg::ROLE_HEADER_OK;
                        phase = btp_pkg::PH_ID;
                    end
                end
                btp_pkg::PH_ID: begin
                    r.object_code = b;
                    if (l) begin
                        // id on the last byte is never looked up
                        r.byte_role = btp_pkg::ROLE_OBJECT_ID;
                        stop_code = btp_pkg::STATUS_TRUNCATED;
                        phase = btp_pkg::PH_IGNORE;
                    end else begin
                        len = value_length(b);
                        if (len == btp_pkg::LEN_UNKNOWN) begin
                            r.byte_role = btp_pkg::ROLE_UNKNOWN_ID;
                            stop_code = btp_pkg::STATUS_UNKNOWN;
                            phase = btp_pkg::PH_IGNORE;
                        end else begin
                            r.byte_role = btp_pkg::ROLE_OBJECT_ID;
                            cur_obj = b;
                            if (len == btp_pkg::LEN_VARIABLE) begin
                                phase = btp_pkg::PH_LENGTH;
                            end else begin
                                remaining = 8'(len);
                                phase = btp_pkg::PH_VALUE;
                            end
                        end
                    end
                end
                btp_pkg::PH_LENGTH: begin
                    r.byte_role = btp_pkg::ROLE_VALUE;
                    r.object_code = cur_obj;
                    if (b == 8'd0) begin
                        r.measurement_done = 1'b1;
                        bump_count();
                        phase = btp_pkg::PH_ID;
                    end else begin
                        remaining = b;
                        phase = btp_pkg::PH_VALUE;
                    end
                end
                btp_pkg::PH_VALUE: begin
                    r.object_code = cur_obj;
                    if (cur_obj == btp_pkg::PACKET_ID_OBJ) begin
                        r.byte_role = btp_pkg::ROLE_PACKET_ID;
                        pkt_num = b;
                    end else begin
                        r.byte_role = btp_pkg::ROLE_VALUE;
                    end
                    if (remaining != 8'd0) remaining = remaining - 8'd1;
                    if (remaining == 8'd0) begin
                        r.measurement_done = 1'b1;
                        if (cur_obj != btp_pkg::PACKET_ID_OBJ) bump_count();
                        phase = btp_pkg::PH_ID;
                    end
                end
                default: r.byte_role = btp_pkg::ROLE_IGNORED;
            endcase
            if (l) begin
                if (phase == btp_pkg::PH_ID)
                    r.end_status = btp_pkg::STATUS_COMPLETE;
                else if (phase == btp_pkg::PH_LENGTH || phase == btp_pkg::PH_VALUE)
                    r.end_status = btp_pkg::STATUS_TRUNCATED;
                else
                    r.end_status = stop_code;
            end
            r.packet_number     = pkt_num;
            r.measurement_total = meas_cnt;
            expected_q.insert(expected_q.size(), r);
            if (l) clear_state();
        endfunction

        // Compare one accepted result against the oldest expectation
        function void check_result(input btp_pkg::btp_result_t got);
            btp_pkg::btp_result_t want;
            string       bad;
            checked++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] result with nothing expected: %h", $realtime, got);
                return;
            end
            want = expected_q.pop_front();
            bad = "";
            if (got.byte_role !== want.byte_role) bad = {bad, " byte_role"};
            if (got.object_code !== want.object_code) bad = {bad, " object_code"};
            if (got.byte_value !== want.byte_value) bad = {bad, " byte_value"};
            if (got.measurement_done !== want.measurement_done) bad = {bad, " measurement_done"};
            if (got.payload_end !== want.payload_end) bad = {bad, " payload_end"};
            if (got.end_status !== want.end_status) bad = {bad, " end_status"};
            if (got.packet_number !== want.packet_number) bad = {bad, " packet_number"};
            if (got.measurement_total !== want.measurement_total)
                bad = {bad, " measurement_total"};
            if (bad != "") begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] mismatch in%s: expected %h, got %h",
                             $realtime, bad, want, got);
            end
            if (want.payload_end) ends[want.end_status]++;
            if (want.measurement_total > peak_total) peak_total = want.measurement_total;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    btp_in_if  in_ch ();
    btp_out_if out_ch ();

    bthome_v2_object_parser uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (in_ch),
        .result  (out_ch)
    );

    parser_scoreboard board = new();

    logic [7:0]  frame_q[$];
    bit          idle_on = 1'b1;
    bit          long_hold_req = 1'b0;
    int unsigned bytes_sent = 0;
    int unsigned frames_sent = 0;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offer one byte, with an optional idle burst first, and wait for its acceptance
    task automatic send_byte(input logic [7:0] b, input logic l);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= l;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        board.note_byte(b, l);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
        frames_sent++;
    endtask

    // Append one byte to the payload being built
    function automatic void add_byte(input logic [7:0] b);
        frame_q.insert(frame_q.size(), b);
    endfunction

    function automatic logic [7:0] good_header();
        return {btp_pkg::BTHOME_VERSION, 4'($urandom_range(0, 15)), 1'b0};
    endfunction

    function automatic logic [7:0] bad_header();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while ((b & btp_pkg::HDR_ENCRYPT_MASK) == 8'd0 && b[7:5] == btp_pkg::BTHOME_VERSION)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] pick_known_id();
        logic [7:0] id;
        case ($urandom_range(0, 9))
            0: id = btp_pkg::PACKET_ID_OBJ;
            1: id = EXT_ID_BASE + 8'($urandom_range(0, 2));
            2: id = $urandom_range(0, 1) ? OBJ_TEXT : OBJ_RAW;
            default:
            begin
                id = 8'($urandom_range(1, TABLE_IDS - 1));
                while (board.value_length(id) == btp_pkg::LEN_UNKNOWN)
                    id = 8'($urandom_range(1, TABLE_IDS - 1));
            end
        endcase
        return id;
    endfunction

    function automatic logic [7:0] pick_unknown_id();
        logic [7:0] id;
        id = 8'($urandom_range(0, 255));
        while (board.value_length(id) != btp_pkg::LEN_UNKNOWN) id = 8'($urandom_range(0, 255));
        return id;
    endfunction

    // Append one whole object: id, length byte where needed, value bytes
    task automatic push_object(input logic [7:0] id);
        int n;
        add_byte(id);
        if (board.value_length(id) == btp_pkg::LEN_VARIABLE)
        begin
            n = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(5, 12);
            add_byte(8'(n));
        end
        else
        begin
            n = int'(board.value_length(id));
        end
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic build_good(input int objs);
        add_byte(good_header());
        repeat (objs) push_object(pick_known_id());
    endtask

    // One random payload: mostly well formed, the rest broken or noise
    task automatic build_random_frame();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 14)
        begin
            build_good($urandom_range(0, 6));
        end
        else if (kind < 16)
        begin
            // cut a valid payload short
            build_good($urandom_range(1, 4));
            repeat ($urandom_range(1, 3))
                if (frame_q.size() > 1) void'(frame_q.pop_back());
        end
        else if (kind == 16)
        begin
            build_good($urandom_range(0, 3));
            add_byte(pick_unknown_id());
            repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
        end
        else if (kind == 17)
        begin
            add_byte(bad_header());
            repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            add_byte(kind == 18 ? 8'($urandom_range(0, 255)) : good_header());
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Result side: random stalls, the long hold-off, and checking
    initial
    begin
        int stall_cnt;
        btp_pkg::btp_result_t got;
        stall_cnt = 0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got.byte_role         = out_ch.byte_role;
                got.object_code       = out_ch.object_code;
                got.byte_value        = out_ch.byte_value;
                got.measurement_done  = out_ch.measurement_done;
                got.payload_end       = out_ch.payload_end;
                got.end_status        = out_ch.end_status;
                got.packet_number     = out_ch.packet_number;
                got.measurement_total = out_ch.measurement_total;
                board.check_result(got);
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_cnt = LONG_HOLD_CYCLES;
            end
            else if (stall_cnt == 0 && idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_cnt = $urandom_range(1, 5);
            end
            if (stall_cnt > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_cnt--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too many cycles without any item moving
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus
    initial
    begin
        bit held, paused, saturated;
        held = 1'b0;
        paused = 1'b0;
        saturated = 1'b0;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'd0;
        in_ch.last_byte <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header alone
        frame_q = '{8'h40};
        send_frame();
        // encrypted header, rest ignored
        frame_q = '{8'h41, 8'hFF, 8'h00};
        send_frame();
        // wrong version, low and high
        frame_q = '{8'h20};
        send_frame();
        frame_q = '{8'hE0};
        send_frame();
        // packet id, zero-length text, raw with length, all in one payload
        frame_q = '{8'h5E, btp_pkg::PACKET_ID_OBJ, 8'hFF, OBJ_TEXT, 8'h00,
                    OBJ_RAW, 8'h02, 8'hAA, 8'h55};
        send_frame();
        // dangling id that would be unknown if looked up
        frame_q = '{8'h40, 8'h30};
        send_frame();
        // unknown id stops parsing
        frame_q = '{8'h40, 8'hFF, 8'h01};
        send_frame();
        // truncated fixed-length value
        frame_q = '{8'h40, EXT_ID_BASE + 8'd1, 8'h01, 8'h02};
        send_frame();
        // payload ends right after a length byte
        frame_q = '{8'h40, OBJ_RAW, 8'h03};
        send_frame();

        while (bytes_sent < ITEM_TARGET)
        begin
            if (!held && bytes_sent >= 150)
            begin
                // receiver holds off while payload bytes keep coming
                held = 1'b1;
                long_hold_req = 1'b1;
            end
            if (!saturated && bytes_sent >= 300)
            begin
                // enough measurements in one payload to saturate the total
                saturated = 1'b1;
                add_byte(good_header());
                repeat (258)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        add_byte(OBJ_TEXT);
                        add_byte(8'd0);
                    end
                    else
                    begin
                        add_byte(OBJ_BATTERY);
                        add_byte(8'($urandom_range(0, 255)));
                    end
                end
                push_object(pick_known_id());
                send_frame();
            end
            if (!paused && bytes_sent >= 700)
            begin
                // sender goes quiet until the block has drained
                paused = 1'b1;
                in_ch.valid <= 1'b0;
                while (board.pending() != 0) @(posedge clk);
            end
            if (bytes_sent >= 950) idle_on = 1'b0;
            build_random_frame();
            send_frame();
        end
        in_ch.valid <= 1'b0;

        while (board.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d payloads, %0d bytes, %0d results; peak total %0d",
                 frames_sent, bytes_sent, board.checked, board.peak_total);
        $display("endings: complete %0d, rejected %0d, truncated %0d, unknown id %0d",
                 board.ends[btp_pkg::STATUS_COMPLETE], board.ends[btp_pkg::STATUS_REJECTED],
                 board.ends[btp_pkg::STATUS_TRUNCATED], board.ends[btp_pkg::STATUS_UNKNOWN]);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/btp_pkg.sv
rtl/core/btp_in_if.sv
rtl/core/btp_out_if.sv
rtl/core/btp_step.sv
rtl/core/bthome_v2_object_parser.sv
tb/sv/bthome_v2_object_parser_test.sv
